### rtl/rku_pkg.sv
// shared constants, codes and handshake structs for the relativistic kinematics unit
package rku_pkg;

    // default sizes and fixed field widths
    localparam int ENERGY_BITS_DEF     = 40;
    localparam int GAMMA_FRAC_BITS_DEF = 24;
    localparam int GAMMA_INT_BITS      = 24;
    localparam int RIGIDITY_W          = 56;
    localparam int BETA_W              = 33;
    localparam int BETA_FRAC           = 32;
    localparam int CHARGE_W            = 8;
    localparam int BEND_W              = 20;
    localparam int BEND_FRAC           = 16;
    localparam int DEN_W               = 52;
    localparam int LIGHT_Q_W           = 37;
    localparam int CNT_W               = 8;
    localparam int MODE_W              = 2;
    localparam int ERR_W               = 2;
    localparam int APB_ADDR_W          = 5;
    localparam int APB_DATA_W          = 64;
    localparam int MASS_RESET          = 938272;

    // physical constants
    localparam logic [29:0] MICRO_PER_GIGA   = 30'd1000000000;
    localparam logic [28:0] LIGHT_SPEED_NANO = 29'd299792458;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK             = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NOT_ABOVE_MASS = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NON_POSITIVE   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_MASS   = 2'd0;
    localparam logic [1:0] REG_CHARGE = 2'd1;
    localparam logic [1:0] REG_BEND   = 2'd2;

    // request modes
    typedef enum logic [MODE_W-1:0] {
        MODE_SET_TOTAL    = 2'd0,
        MODE_SET_KINETIC  = 2'd1,
        MODE_SET_MOMENTUM = 2'd2,
        MODE_ADD_KINETIC  = 2'd3
    } mode_t;

    // operations of the shared iterative unit
    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } iter_op_t;

    typedef struct packed {
        logic             start;
        iter_op_t         op;
        logic [CNT_W-1:0] count;
    } iter_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_stat_t;

endpackage

### rtl/rku_iter_unit.sv
// shared iterative unit: shift-add multiply, restoring divide, digit-by-digit square root
module rku_iter_unit #(
    parameter int N_W = 90,
    parameter int A_W = 52
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rku_pkg::iter_ctrl_t   ctrl,
    input  logic [A_W-1:0]        a_in,
    input  logic [N_W-1:0]        n_in,
    output rku_pkg::iter_stat_t   stat,
    output logic [N_W-1:0]        q_out
);
    import rku_pkg::*;

    localparam int R_W  = A_W;
    localparam int SH_W = R_W + 2;

    iter_op_t         op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [A_W-1:0]   a_reg;
    logic [N_W-1:0]   n_reg;
    logic [N_W-1:0]   q_reg;
    logic [R_W-1:0]   r_reg;

    logic [SH_W-1:0]  sh;
    logic [SH_W-1:0]  trial;
    logic [SH_W-1:0]  diff;
    logic             ge;
    logic [N_W-1:0]   acc_sum;

    // partial remainder and trial value for the compare and subtract
    always_comb
    begin
        unique case (op_reg)
            OP_DIV:
            begin
                sh    = {1'b0, r_reg, n_reg[N_W-1]};
                trial = {2'b00, a_reg};
            end
            OP_SQRT:
            begin
                sh    = {r_reg, n_reg[N_W-1 -: 2]};
                trial = {q_reg[SH_W-3:0], 2'b01};
            end
            default:
            begin
                sh    = '0;
                trial = '0;
            end
        endcase
    end

    assign ge   = (sh >= trial);
    assign diff = sh - trial;

    // shift-add accumulate, multiplier bits taken from the top
    assign acc_sum = {q_reg[N_W-2:0], 1'b0} + (n_reg[N_W-1] ? N_W'(a_reg) : '0);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                op_reg   <= ctrl.op;
                cnt_reg  <= ctrl.count;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            a_reg <= a_in;
            n_reg <= n_in;
            q_reg <= '0;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    q_reg <= acc_sum;
                    n_reg <= {n_reg[N_W-2:0], 1'b0};
                end
                OP_DIV:
                begin
                    r_reg <= ge ? diff[R_W-1:0] : sh[R_W-1:0];
                    q_reg <= {q_reg[N_W-2:0], ge};
                    n_reg <= {n_reg[N_W-2:0], 1'b0};
                end
                OP_SQRT:
                begin
                    r_reg <= ge ? diff[R_W-1:0] : sh[R_W-1:0];
                    q_reg <= {q_reg[N_W-2:0], ge};
                    n_reg <= {n_reg[N_W-3:0], 2'b00};
                end
                default:
                begin
                    q_reg <= q_reg;
                end
            endcase
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign q_out     = q_reg;

    // checks
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("iterative unit started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without a running operation");

    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> ctrl.count != '0)
        else $error("operation started with zero iterations");

endmodule

### rtl/relativistic_kinematics_unit_top.sv
// relativistic kinematics unit: configuration, sequencer and result register
//
//  channel   direction  handshake           payload
//  in        input      in_valid/in_stall   mode, value
//  out       output     out_valid/out_stall total_energy .. error_code
//  apb       input      psel/penable/pready paddr, pwdata, prdata
//
// a request is computed by the bit-per-cycle iterations of the shared unit; a given momentum
// needs two multiply passes (mass squared, momentum squared) instead of one, and the divisions
// and the rigidity passes can be skipped. an erroneous request goes from validation straight
// to the output state.
// in_stall is high from acceptance until the result is loaded into the output register.
// a stalled result holds the block in its final state until the result is taken.
// rst_n clears the configuration to its defaults, the stored energy to zero and
// the direction to forwards.
module relativistic_kinematics_unit_top #(
    parameter int ENERGY_BITS     = rku_pkg::ENERGY_BITS_DEF,
    parameter int GAMMA_FRAC_BITS = rku_pkg::GAMMA_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rku_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [rku_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [rku_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [rku_pkg::MODE_W-1:0]             mode,
    input  logic signed [ENERGY_BITS:0]            value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [ENERGY_BITS:0]                   total_energy,
    output logic [ENERGY_BITS-1:0]                 kinetic_energy,
    output logic [ENERGY_BITS:0]                   momentum,
    output logic [rku_pkg::GAMMA_INT_BITS+GAMMA_FRAC_BITS-1:0] lorentz_gamma,
    output logic [rku_pkg::BETA_W-1:0]             velocity_beta,
    output logic signed [rku_pkg::RIGIDITY_W-1:0]  rigidity,
    output logic                                   moving_forward,
    output logic [rku_pkg::ERR_W-1:0]              error_code
);
    import rku_pkg::*;

    localparam int E   = ENERGY_BITS;
    localparam int NW0 = (E + 50 > 2 * E + 2) ? E + 50 : 2 * E + 2;
    localparam int N_W = NW0 + (NW0 % 2);
    localparam int A_W = (E + 2 > DEN_W) ? E + 2 : DEN_W;
    localparam int G_W = GAMMA_INT_BITS + GAMMA_FRAC_BITS;

    localparam logic [G_W-1:0]        GMAX        = '1;
    localparam logic [BETA_W-1:0]     BETA_CAP    = BETA_W'(1) << BETA_FRAC;
    localparam logic [RIGIDITY_W-1:0] RIG_POS_CAP = {1'b0, {(RIGIDITY_W-1){1'b1}}};
    localparam logic [RIGIDITY_W-1:0] RIG_NEG_CAP = {1'b1, {(RIGIDITY_W-1){1'b0}}};

    typedef enum logic [11:0] {
        S_IDLE   = 12'h001,
        S_CHECK  = 12'h002,
        S_MUL_MM = 12'h004,
        S_MUL_PP = 12'h008,
        S_MUL_K  = 12'h010,
        S_SQRT   = 12'h020,
        S_GAMMA  = 12'h040,
        S_BETA   = 12'h080,
        S_RIG_A  = 12'h100,
        S_RIG_B  = 12'h200,
        S_RIG_C  = 12'h400,
        S_OUT    = 12'h800
    } state_t;

    state_t                  state_reg;
    logic                    launched_reg;

    // configuration and persistent state
    logic [E-1:0]            mass_reg;
    logic signed [CHARGE_W-1:0] charge_reg;
    logic signed [BEND_W-1:0]   bend_reg;
    logic [E-1:0]            kin_reg;
    logic                    fwd_reg;

    // request and working registers
    logic [MODE_W-1:0]       mode_reg;
    logic signed [E:0]       v_reg;
    logic [E:0]              e_reg;
    logic [E-1:0]            k_reg;
    logic [E:0]              p_reg;
    logic                    fwdn_reg;
    logic [ERR_W-1:0]        err_reg;
    logic [N_W-1:0]          tmp_reg;
    logic [G_W-1:0]          gamma_reg;
    logic [BETA_W-1:0]       beta_reg;
    logic [RIGIDITY_W-1:0]   rig_reg;

    // output register
    logic                    out_valid_reg;
    logic [E:0]              total_energy_reg;
    logic [E-1:0]            kinetic_energy_reg;
    logic [E:0]              momentum_reg;
    logic [G_W-1:0]          lorentz_gamma_reg;
    logic [BETA_W-1:0]       velocity_beta_reg;
    logic [RIGIDITY_W-1:0]   rigidity_reg;
    logic                    moving_forward_reg;
    logic [ERR_W-1:0]        error_code_reg;

    logic                    cfg_wr;
    logic [1:0]              cfg_idx;
    logic                    accept;
    logic                    out_load;

    iter_ctrl_t              ctrl;
    iter_stat_t              stat;
    logic [A_W-1:0]          unit_a;
    logic [N_W-1:0]          unit_n;
    logic [N_W-1:0]          unit_q;
    logic                    compute;
    logic                    skip;
    logic                    fin;

    // request checks
    logic signed [E+1:0]     v_ext;
    logic signed [E+1:0]     mass_s;
    logic signed [E+1:0]     nk;
    logic [E+1:0]            nk_mag;
    logic [E-1:0]            nk_sat;
    logic                    v_zero;
    logic                    v_pos;
    logic [ERR_W-1:0]        chk_err;
    logic [E-1:0]            chk_k;
    logic                    chk_fwd;

    // rigidity operands
    logic [BEND_W-1:0]       bend_abs;
    logic [CHARGE_W-1:0]     charge_abs;
    logic [LIGHT_Q_W-1:0]    light_q;
    logic [A_W-1:0]          den;
    logic                    rig_neg;
    logic [RIGIDITY_W-1:0]   rig_cap;
    logic [RIGIDITY_W-1:0]   rig_mag;

    // apb port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:3];

    always_comb
    begin
        unique case (cfg_idx)
            REG_MASS:   prdata = APB_DATA_W'(mass_reg);
            REG_CHARGE: prdata = {{(APB_DATA_W-CHARGE_W){1'b0}}, charge_reg};
            REG_BEND:   prdata = {{(APB_DATA_W-BEND_W){1'b0}}, bend_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg   <= E'(MASS_RESET);
            charge_reg <= CHARGE_W'(1);
            bend_reg   <= BEND_W'(1) << BEND_FRAC;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MASS:   mass_reg   <= pwdata[E-1:0];
                REG_CHARGE: charge_reg <= pwdata[CHARGE_W-1:0];
                REG_BEND:   bend_reg   <= pwdata[BEND_W-1:0];
                default:    mass_reg   <= mass_reg;
            endcase
        end
    end

    // handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid & ~in_stall;
    assign out_load  = (state_reg == S_OUT) & (~out_valid_reg | ~out_stall);
    assign out_valid = out_valid_reg;

    // request validation and new kinetic energy
    assign v_ext  = {v_reg[E], v_reg};
    assign mass_s = {2'b00, mass_reg};
    assign nk     = $signed({2'b00, kin_reg}) + v_ext;
    assign nk_mag = nk[E+1] ? (E+2)'(-nk) : (E+2)'(nk);
    assign nk_sat = (|nk_mag[E+1:E]) ? '1 : nk_mag[E-1:0];
    assign v_zero = (v_reg == '0);
    assign v_pos  = ~v_reg[E] & ~v_zero;

    always_comb
    begin
        chk_err = ERR_OK;
        chk_k   = '0;
        chk_fwd = fwd_reg;
        unique case (mode_t'(mode_reg))
            MODE_SET_TOTAL:
            begin
                if (v_zero)
                    chk_err = ERR_NON_POSITIVE;
                else if (v_ext <= mass_s)
                    chk_err = ERR_NOT_ABOVE_MASS;
                chk_k = v_reg[E-1:0] - mass_reg;
            end
            MODE_SET_KINETIC:
            begin
                if (!v_pos)
                    chk_err = ERR_NON_POSITIVE;
                chk_k = v_reg[E-1:0];
            end
            MODE_SET_MOMENTUM:
            begin
                if (!v_pos)
                    chk_err = ERR_NON_POSITIVE;
            end
            MODE_ADD_KINETIC:
            begin
                if (v_zero)
                    chk_k = kin_reg;
                else
                begin
                    chk_k = nk_sat;
                    if (nk_sat == '0)
                        chk_err = ERR_NON_POSITIVE;
                    if (nk[E+1])
                        chk_fwd = ~fwd_reg;
                end
            end
            default:
            begin
                chk_err = ERR_OK;
            end
        endcase
    end

    // rigidity operands
    assign bend_abs   = bend_reg[BEND_W-1] ? BEND_W'(-bend_reg) : BEND_W'(bend_reg);
    assign charge_abs = charge_reg[CHARGE_W-1] ? CHARGE_W'(-charge_reg)
                                               : CHARGE_W'(charge_reg);
    assign light_q    = LIGHT_Q_W'(LIGHT_SPEED_NANO) * LIGHT_Q_W'(charge_abs);
    assign den        = A_W'(light_q) << BEND_FRAC;
    assign rig_neg    = bend_reg[BEND_W-1] ^ charge_reg[CHARGE_W-1];
    assign rig_cap    = rig_neg ? RIG_NEG_CAP : RIG_POS_CAP;
    assign rig_mag    = (unit_q > N_W'(rig_cap)) ? rig_cap : unit_q[RIGIDITY_W-1:0];

    // operand selection for the shared unit
    always_comb
    begin
        compute    = 1'b1;
        skip       = 1'b0;
        ctrl.op    = OP_MUL;
        ctrl.count = CNT_W'(E);
        unit_a     = '0;
        unit_n     = '0;
        unique case (state_reg)
            S_MUL_MM:
            begin
                unit_a = A_W'(mass_reg);
                unit_n = N_W'(mass_reg) << (N_W - E);
            end
            S_MUL_PP:
            begin
                ctrl.count = CNT_W'(E + 1);
                unit_a     = A_W'(p_reg);
                unit_n     = N_W'(p_reg) << (N_W - E - 1);
            end
            S_MUL_K:
            begin
                unit_a = (A_W'(mass_reg) << 1) + A_W'(k_reg);
                unit_n = N_W'(k_reg) << (N_W - E);
            end
            S_SQRT:
            begin
                ctrl.op    = OP_SQRT;
                ctrl.count = CNT_W'(N_W / 2);
                unit_n     = tmp_reg;
            end
            S_GAMMA:
            begin
                skip       = (mass_reg == '0);
                ctrl.op    = OP_DIV;
                ctrl.count = CNT_W'(N_W);
                unit_a     = A_W'(mass_reg);
                unit_n     = N_W'(e_reg) << GAMMA_FRAC_BITS;
            end
            S_BETA:
            begin
                skip       = (e_reg == '0);
                ctrl.op    = OP_DIV;
                ctrl.count = CNT_W'(N_W);
                unit_a     = A_W'(e_reg);
                unit_n     = N_W'(p_reg) << BETA_FRAC;
            end
            S_RIG_A:
            begin
                skip       = (charge_reg == '0) | (bend_reg == '0);
                ctrl.count = CNT_W'(BEND_W);
                unit_a     = A_W'(MICRO_PER_GIGA);
                unit_n     = N_W'(bend_abs) << (N_W - BEND_W);
            end
            S_RIG_B:
            begin
                ctrl.count = CNT_W'(E + 1);
                unit_a     = tmp_reg[A_W-1:0];
                unit_n     = N_W'(p_reg) << (N_W - E - 1);
            end
            S_RIG_C:
            begin
                ctrl.op    = OP_DIV;
                ctrl.count = CNT_W'(N_W);
                unit_a     = den;
                unit_n     = tmp_reg;
            end
            default:
            begin
                compute = 1'b0;
            end
        endcase
        ctrl.start = compute & ~launched_reg & ~skip;
    end

    assign fin = stat.done;

    rku_iter_unit #(
        .N_W (N_W),
        .A_W (A_W)
    ) u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .a_in  (unit_a),
        .n_in  (unit_n),
        .stat  (stat),
        .q_out (unit_q)
    );

    // sequencer and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            kin_reg       <= '0;
            fwd_reg       <= 1'b1;
        end
        else
        begin
            if (ctrl.start)
                launched_reg <= 1'b1;
            else if (fin)
                launched_reg <= 1'b0;

            out_valid_reg <= out_load | (out_valid_reg & out_stall);

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (chk_err != ERR_OK)
                        state_reg <= S_OUT;
                    else if (mode_t'(mode_reg) == MODE_SET_MOMENTUM)
                        state_reg <= S_MUL_MM;
                    else
                        state_reg <= S_MUL_K;
                end
                S_MUL_MM:
                begin
                    if (fin)
                        state_reg <= S_MUL_PP;
                end
                S_MUL_PP, S_MUL_K:
                begin
                    if (fin)
                        state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (fin)
                        state_reg <= S_GAMMA;
                end
                S_GAMMA:
                begin
                    if (skip || fin)
                        state_reg <= S_BETA;
                end
                S_BETA:
                begin
                    if (skip || fin)
                        state_reg <= S_RIG_A;
                end
                S_RIG_A:
                begin
                    if (skip)
                        state_reg <= S_OUT;
                    else if (fin)
                        state_reg <= S_RIG_B;
                end
                S_RIG_B:
                begin
                    if (fin)
                        state_reg <= S_RIG_C;
                end
                S_RIG_C:
                begin
                    if (fin)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                        if (err_reg == ERR_OK)
                        begin
                            kin_reg <= k_reg;
                            fwd_reg <= fwdn_reg;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            v_reg    <= value;
        end
        if (state_reg == S_CHECK)
        begin
            err_reg  <= chk_err;
            k_reg    <= chk_k;
            fwdn_reg <= chk_fwd;
            e_reg    <= (E+1)'(mass_reg) + (E+1)'(chk_k);
            p_reg    <= v_reg[E:0];
        end
        if (fin)
        begin
            unique case (state_reg)
                S_MUL_MM, S_MUL_K, S_RIG_A, S_RIG_B:
                    tmp_reg <= unit_q;
                S_MUL_PP:
                    tmp_reg <= tmp_reg + unit_q;
                S_SQRT:
                begin
                    if (mode_t'(mode_reg) == MODE_SET_MOMENTUM)
                    begin
                        e_reg <= unit_q[E:0];
                        k_reg <= E'(unit_q[E:0] - (E+1)'(mass_reg));
                    end
                    else
                        p_reg <= unit_q[E:0];
                end
                S_GAMMA:
                    gamma_reg <= (unit_q > N_W'(GMAX)) ? GMAX : unit_q[G_W-1:0];
                S_BETA:
                    beta_reg <= (unit_q > N_W'(BETA_CAP)) ? BETA_CAP : unit_q[BETA_W-1:0];
                S_RIG_C:
                    rig_reg <= rig_neg ? RIGIDITY_W'(-rig_mag) : rig_mag;
                default:
                    tmp_reg <= tmp_reg;
            endcase
        end
        else if (skip)
        begin
            unique case (state_reg)
                S_GAMMA: gamma_reg <= GMAX;
                S_BETA:  beta_reg  <= '0;
                S_RIG_A: rig_reg   <= (charge_reg == '0) ? RIG_POS_CAP : '0;
                default: rig_reg   <= rig_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            error_code_reg <= err_reg;
            if (err_reg != ERR_OK)
            begin
                total_energy_reg   <= '0;
                kinetic_energy_reg <= '0;
                momentum_reg       <= '0;
                lorentz_gamma_reg  <= '0;
                velocity_beta_reg  <= '0;
                rigidity_reg       <= '0;
                moving_forward_reg <= fwd_reg;
            end
            else
            begin
                total_energy_reg   <= e_reg;
                kinetic_energy_reg <= k_reg;
                momentum_reg       <= p_reg;
                lorentz_gamma_reg  <= gamma_reg;
                velocity_beta_reg  <= beta_reg;
                rigidity_reg       <= rig_reg;
                moving_forward_reg <= fwdn_reg;
            end
        end
    end

    assign total_energy   = total_energy_reg;
    assign kinetic_energy = kinetic_energy_reg;
    assign momentum       = momentum_reg;
    assign lorentz_gamma  = lorentz_gamma_reg;
    assign velocity_beta  = velocity_beta_reg;
    assign rigidity       = rigidity_reg;
    assign moving_forward = moving_forward_reg;
    assign error_code     = error_code_reg;

    // checks
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_CHECK)
        else $error("accepted request did not enter validation");

    a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code != ERR_OK) |->
            (total_energy == '0 && momentum == '0 && rigidity == '0))
        else $error("erroneous result carries nonzero fields");

    a_state_update_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(kin_reg) |-> $past(state_reg == S_OUT))
        else $error("stored kinetic energy changed outside result load");

endmodule
